@@ src/assert_macros.svh @@
// ----------------------------------------------------------------------------
// Assertion macros
// Shared concurrent assertion wrappers; define ASSERT_OFF to compile them out.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF
`define XRR_ASSERT(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) \
        else $error("assertion failed");
`define XRR_ASSERT_NEVER(lbl, clk, rst_n, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(expr)) \
        else $error("forbidden condition seen");
`else
`define XRR_ASSERT(lbl, clk, rst_n, prop)
`define XRR_ASSERT_NEVER(lbl, clk, rst_n, expr)
`endif

`endif

@@ src/xrr_pkg.sv @@
// ----------------------------------------------------------------------------
// xrr_pkg
// Constants, mode codes and controller/datapath interface types.
// ----------------------------------------------------------------------------
package xrr_pkg;

    localparam int DATA_W = 32;
    localparam int CNT_W  = $clog2(DATA_W);

    localparam int SHIFT_A = 13;
    localparam int SHIFT_B = 17;
    localparam int SHIFT_C = 5;

    localparam logic [DATA_W-1:0] SCRAMBLE_MUL = 32'd314159265;
    localparam logic [DATA_W-1:0] SEED_RESET   = 32'd1;
    localparam logic [CNT_W-1:0]  DIV_LAST     = CNT_W'(DATA_W - 1);

    localparam logic [2:0] MODE_RAW    = 3'd0;
    localparam logic [2:0] MODE_MOD    = 3'd1;
    localparam logic [2:0] MODE_RANGE  = 3'd2;
    localparam logic [2:0] MODE_CHANCE = 3'd3;
    localparam logic [2:0] MODE_HASH   = 3'd4;

    typedef struct packed {
        logic seed_load;
        logic load;
        logic scramble;
        logic div_step;
        logic add;
        logic chmul;
        logic chcmp;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic use_div;
        logic use_chance;
        logic div_last;
    } t_sts;

    function automatic logic [DATA_W-1:0] mix(input logic [DATA_W-1:0] x);
        logic [DATA_W-1:0] y;
        y = x ^ (x << SHIFT_A);
        y = y ^ (y >> SHIFT_B);
        y = y ^ (y << SHIFT_C);
        return y;
    endfunction

endpackage

@@ src/xrr_ctrl.sv @@
// ----------------------------------------------------------------------------
// xrr_ctrl
// Sequencer: accept a transaction, step the datapath, hand off the result.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xrr_ctrl
    import xrr_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_valid,
    output logic o_stall,
    input  logic i_cfg_valid,
    output logic o_cfg_ready,
    output logic o_valid,
    input  logic i_stall,
    input  t_sts i_sts,
    output t_cmd o_cmd
);

    typedef enum logic [6:0] {
        S_IDLE = 7'b0000001,
        S_SCR  = 7'b0000010,
        S_DIV  = 7'b0000100,
        S_ADD  = 7'b0001000,
        S_CMUL = 7'b0010000,
        S_CCMP = 7'b0100000,
        S_DONE = 7'b1000000
    } t_state;

    t_state r_state, n_state;
    logic   r_out_valid, n_out_valid;
    t_cmd   cmd;

    assign o_stall     = (r_state != S_IDLE) || i_cfg_valid;
    assign o_cfg_ready = (r_state == S_IDLE);
    assign o_valid     = r_out_valid;
    assign o_cmd       = cmd;

    always_comb begin
        n_state     = r_state;
        cmd         = '0;
        n_out_valid = r_out_valid;
        if (r_out_valid && !i_stall) begin
            n_out_valid = 1'b0;
        end
        unique case (r_state)
            S_IDLE: begin
                if (i_cfg_valid) begin
                    cmd.seed_load = 1'b1;
                end else if (i_valid) begin
                    cmd.load = 1'b1;
                    n_state  = S_SCR;
                end
            end
            S_SCR: begin
                cmd.scramble = 1'b1;
                if (i_sts.use_div) begin
                    n_state = S_DIV;
                end else if (i_sts.use_chance) begin
                    n_state = S_CMUL;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_DIV: begin
                cmd.div_step = 1'b1;
                if (i_sts.div_last) begin
                    n_state = S_ADD;
                end
            end
            S_ADD: begin
                cmd.add = 1'b1;
                n_state = S_DONE;
            end
            S_CMUL: begin
                cmd.chmul = 1'b1;
                n_state   = S_CCMP;
            end
            S_CCMP: begin
                cmd.chcmp = 1'b1;
                n_state   = S_DONE;
            end
            S_DONE: begin
                if (!r_out_valid || !i_stall) begin
                    cmd.out_load = 1'b1;
                    n_out_valid  = 1'b1;
                    n_state      = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_out_valid <= n_out_valid;
        end
    end

    `XRR_ASSERT(a_accept_starts, i_clk, i_rst_n, (i_valid && !o_stall) |=> (r_state == S_SCR))
    `XRR_ASSERT(a_div_ends, i_clk, i_rst_n, (r_state == S_DIV && i_sts.div_last) |=> (r_state == S_ADD))
    `XRR_ASSERT_NEVER(a_no_overwrite, i_clk, i_rst_n, cmd.out_load && r_out_valid && i_stall)

endmodule

@@ src/xrr_dp.sv @@
// ----------------------------------------------------------------------------
// xrr_dp
// Generator state, shared multiplier, bit-serial remainder and chance compare.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module xrr_dp
    import xrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  t_cmd              i_cmd,
    output t_sts              o_sts,
    input  logic [DATA_W-1:0] i_seed,
    input  logic [2:0]        i_mode,
    input  logic [DATA_W-1:0] i_limit_low,
    input  logic [DATA_W-1:0] i_limit_high,
    input  logic [DATA_W-1:0] i_chance_num,
    input  logic [DATA_W-1:0] i_chance_den,
    input  logic [DATA_W-1:0] i_hash_offset,
    output logic [DATA_W-1:0] o_value,
    output logic              o_hit
);

    logic [DATA_W-1:0]   r_gen;
    logic [2:0]          r_mode;
    logic [DATA_W-1:0]   r_mixed;
    logic [DATA_W-1:0]   r_num;
    logic [DATA_W-1:0]   r_den;
    logic [DATA_W-1:0]   r_span;
    logic [DATA_W-1:0]   r_base;
    logic [DATA_W-1:0]   r_val;
    logic [DATA_W-1:0]   r_rem;
    logic [CNT_W-1:0]    r_cnt;
    logic [2*DATA_W-1:0] r_prod;
    logic                r_hit;
    logic [DATA_W-1:0]   r_out_value;
    logic                r_out_hit;

    logic              lo_gt;
    logic [DATA_W-1:0] rng_base;
    logic [DATA_W-1:0] rng_top;
    logic [DATA_W-1:0] mul_a;
    logic [DATA_W-1:0] mul_b;
    logic [2*DATA_W-1:0] mul_p;
    logic [2*DATA_W-1:0] rhs;
    logic [DATA_W:0]   trial;
    logic [DATA_W:0]   trial_sub;

    assign lo_gt    = i_limit_low > i_limit_high;
    assign rng_base = lo_gt ? i_limit_high : i_limit_low;
    assign rng_top  = lo_gt ? i_limit_low : i_limit_high;

    assign mul_a = i_cmd.scramble ? r_mixed : r_val;
    assign mul_b = i_cmd.scramble ? SCRAMBLE_MUL : r_den;
    assign mul_p = {{DATA_W{1'b0}}, mul_a} * {{DATA_W{1'b0}}, mul_b};

    // num * (2^32 - 1) = (num << 32) - num
    assign rhs = {r_num, {DATA_W{1'b0}}} - {{DATA_W{1'b0}}, r_num};

    assign trial     = {r_rem, r_val[DATA_W-1]};
    assign trial_sub = trial - {1'b0, r_span};

    assign o_sts.use_div    = ((r_mode == MODE_MOD) || (r_mode == MODE_RANGE))
                              && (r_span != '0);
    assign o_sts.use_chance = (r_mode == MODE_CHANCE);
    assign o_sts.div_last   = (r_cnt == DIV_LAST);

    assign o_value = r_out_value;
    assign o_hit   = r_out_hit;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_gen <= SEED_RESET;
        end else if (i_cmd.seed_load) begin
            r_gen <= i_seed;
        end else if (i_cmd.load && (i_mode != MODE_HASH)) begin
            r_gen <= mix(r_gen);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mode  <= i_mode;
            r_num   <= i_chance_num;
            r_den   <= i_chance_den;
            r_hit   <= 1'b0;
            r_mixed <= mix((i_mode == MODE_HASH) ? i_hash_offset : r_gen);
            if (i_mode == MODE_RANGE) begin
                r_base <= rng_base;
                r_span <= rng_top - rng_base + 32'd1;
            end else begin
                r_base <= '0;
                r_span <= i_limit_high + 32'd1;
            end
        end
        if (i_cmd.scramble) begin
            r_val <= mul_p[DATA_W-1:0];
            r_rem <= '0;
            r_cnt <= '0;
        end
        if (i_cmd.div_step) begin
            r_val <= r_val << 1;
            r_cnt <= r_cnt + 1'b1;
            if (!trial_sub[DATA_W]) begin
                r_rem <= trial_sub[DATA_W-1:0];
            end else begin
                r_rem <= trial[DATA_W-1:0];
            end
        end
        if (i_cmd.add) begin
            r_val <= r_rem + r_base;
        end
        if (i_cmd.chmul) begin
            r_prod <= mul_p;
        end
        if (i_cmd.chcmp) begin
            r_hit <= r_prod < rhs;
        end
        if (i_cmd.out_load) begin
            r_out_value <= r_val;
            r_out_hit   <= r_hit;
        end
    end

    `XRR_ASSERT(a_rem_bound, i_clk, i_rst_n, i_cmd.div_step |=> (r_rem < r_span))
    `XRR_ASSERT(a_hash_keeps_state, i_clk, i_rst_n, (i_cmd.load && !i_cmd.seed_load && i_mode == MODE_HASH) |=> $stable(r_gen))

endmodule

@@ src/xorshift_range_random.sv @@
// Accept, then scramble on the shared 32x32 multiplier; modulo and range (nonzero span)
// then run the 32-step bit-serial remainder and add the base, chance multiplies and compares,
// raw and hash go to the output. Input stalls until the result is in the output register.
// A finished result waits in the output register while the next transaction is taken.
// Reset (synchronous, active low) loads the generator state with 1 and clears control.
// ----------------------------------------------------------------------------
// xorshift_range_random
// Xorshift generator with multiplicative scrambler, bounded and chance outputs.
// ----------------------------------------------------------------------------
module xorshift_range_random
    import xrr_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_valid,
    output logic              o_stall,
    input  logic [2:0]        i_mode,
    input  logic [DATA_W-1:0] i_limit_low,
    input  logic [DATA_W-1:0] i_limit_high,
    input  logic [DATA_W-1:0] i_chance_num,
    input  logic [DATA_W-1:0] i_chance_den,
    input  logic [DATA_W-1:0] i_hash_offset,
    output logic              o_valid,
    input  logic              i_stall,
    output logic [DATA_W-1:0] o_value,
    output logic              o_hit,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [DATA_W-1:0] i_seed
);

    t_cmd cmd;
    t_sts sts;

    xrr_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_valid     (i_valid),
        .o_stall     (o_stall),
        .i_cfg_valid (i_cfg_valid),
        .o_cfg_ready (o_cfg_ready),
        .o_valid     (o_valid),
        .i_stall     (i_stall),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    xrr_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_seed        (i_seed),
        .i_mode        (i_mode),
        .i_limit_low   (i_limit_low),
        .i_limit_high  (i_limit_high),
        .i_chance_num  (i_chance_num),
        .i_chance_den  (i_chance_den),
        .i_hash_offset (i_hash_offset),
        .o_value       (o_value),
        .o_hit         (o_hit)
    );

endmodule

@@ test/xorshift_range_random_test.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// xorshift_range_random_test
// Drives requests in every mode across several seeds and checks each result
// against an in-bench predictor of the generator state; random stalls on both
// sides, a steady stretch, and one long output hold-off that backs up input.
// ----------------------------------------------------------------------------
module xorshift_range_random_test;
    import xrr_pkg::*;

    localparam int WATCHDOG_LIMIT = 5000;
    localparam int DRAIN_CYCLES   = 40;
    localparam int HOLD_OFF       = 300;
    localparam int HOLD_AT        = 600;

    typedef struct packed {
        logic [2:0]        mode;
        logic [DATA_W-1:0] limit_low;
        logic [DATA_W-1:0] limit_high;
        logic [DATA_W-1:0] chance_num;
        logic [DATA_W-1:0] chance_den;
        logic [DATA_W-1:0] hash_offset;
    } t_request;

    typedef struct {
        logic [DATA_W-1:0] value;
        logic              hit;
    } t_draw;

    class draw_predictor;
        logic [DATA_W-1:0] seed_reg;
        logic [DATA_W-1:0] gen_state;
        t_draw             expected_draws[$];
        int                errors;

        function new();
            seed_reg  = SEED_RESET;
            gen_state = SEED_RESET;
            errors    = 0;
        endfunction

        function void load_seed(logic [DATA_W-1:0] value);
            seed_reg  = value;
            gen_state = value;
        endfunction

        function logic [DATA_W-1:0] shuffle(logic [DATA_W-1:0] x);
            logic [DATA_W-1:0] t;
            t = x ^ (x << 13);
            t = t ^ (t >> 17);
            t = t ^ (t << 5);
            return t;
        endfunction

        function logic [DATA_W-1:0] next_draw();
            gen_state = shuffle(gen_state);
            return gen_state * SCRAMBLE_MUL;
        endfunction

        function void note_request(t_request r);
            t_draw             d;
            logic [DATA_W-1:0] raw;
            logic [DATA_W-1:0] base;
            logic [DATA_W-1:0] top;
            logic [DATA_W-1:0] span;
            logic [63:0]       lhs;
            logic [63:0]       rhs;
            d.hit = 1'b0;
            case (r.mode)
                MODE_HASH: begin
                    d.value = shuffle(r.hash_offset) * SCRAMBLE_MUL;
                end
                MODE_MOD: begin
                    raw  = next_draw();
                    span = r.limit_high + 32'd1;
                    d.value = (span == 0) ? raw : raw % span;
                end
                MODE_RANGE: begin
                    raw  = next_draw();
                    base = (r.limit_low > r.limit_high) ? r.limit_high : r.limit_low;
                    top  = (r.limit_low > r.limit_high) ? r.limit_low : r.limit_high;
                    span = top - base + 32'd1;
                    d.value = (span == 0) ? raw : (raw % span) + base;
                end
                MODE_CHANCE: begin
                    raw = next_draw();
                    lhs = {32'd0, raw} * {32'd0, r.chance_den};
                    rhs = {32'd0, r.chance_num} * 64'h0000_0000_FFFF_FFFF;
                    d.value = raw;
                    d.hit   = (lhs < rhs);
                end
                default: begin
                    d.value = next_draw();
                end
            endcase
            expected_draws.push_back(d);
        endfunction

        function void check_draw(logic [DATA_W-1:0] value, logic hit);
            t_draw d;
            if (expected_draws.size() == 0) begin
                $display("%0t: unexpected result value=%h hit=%b", $time, value, hit);
                errors++;
                return;
            end
            d = expected_draws.pop_front();
            if (value !== d.value) begin
                $display("%0t: value mismatch: expected %h, actual %h", $time, d.value, value);
                errors++;
            end
            if (hit !== d.hit) begin
                $display("%0t: hit mismatch: expected %b, actual %b", $time, d.hit, hit);
                errors++;
            end
        endfunction

        function int pending();
            return expected_draws.size();
        endfunction
    endclass

    logic              i_clk = 1'b0;
    logic              i_rst_n;
    logic              i_valid;
    logic              o_stall;
    logic [2:0]        i_mode;
    logic [DATA_W-1:0] i_limit_low;
    logic [DATA_W-1:0] i_limit_high;
    logic [DATA_W-1:0] i_chance_num;
    logic [DATA_W-1:0] i_chance_den;
    logic [DATA_W-1:0] i_hash_offset;
    logic              o_valid;
    logic              i_stall;
    logic [DATA_W-1:0] o_value;
    logic              o_hit;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [DATA_W-1:0] i_seed;

    draw_predictor draws = new();
    bit            steady = 1'b0;
    int            results_seen = 0;

    xorshift_range_random dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_mode       (i_mode),
        .i_limit_low  (i_limit_low),
        .i_limit_high (i_limit_high),
        .i_chance_num (i_chance_num),
        .i_chance_den (i_chance_den),
        .i_hash_offset(i_hash_offset),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_value      (o_value),
        .o_hit        (o_hit),
        .i_cfg_valid  (i_cfg_valid),
        .o_cfg_ready  (o_cfg_ready),
        .i_seed       (i_seed)
    );

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    function automatic t_request make_request(logic [2:0] mode, logic [31:0] lo,
                                              logic [31:0] hi, logic [31:0] num,
                                              logic [31:0] den, logic [31:0] off);
        t_request r;
        r.mode        = mode;
        r.limit_low   = lo;
        r.limit_high  = hi;
        r.chance_num  = num;
        r.chance_den  = den;
        r.hash_offset = off;
        return r;
    endfunction

    function automatic logic [31:0] pick_word();
        case ($urandom_range(0, 7))
            0, 1, 2: return $urandom;
            3:       return $urandom_range(0, 15);
            4:       return 32'hFFFF_FFFF - $urandom_range(0, 15);
            5:       return $urandom_range(0, 1) ? 32'hFFFF_FFFF : 32'd0;
            default: return $urandom >> $urandom_range(0, 31);
        endcase
    endfunction

    function automatic t_request random_request();
        t_request    r;
        int unsigned pick;
        r.limit_low   = pick_word();
        r.limit_high  = pick_word();
        r.chance_num  = pick_word();
        r.chance_den  = pick_word();
        r.hash_offset = pick_word();
        pick = $urandom_range(0, 99);
        if (pick < 15)      r.mode = MODE_RAW;
        else if (pick < 35) r.mode = MODE_MOD;
        else if (pick < 60) r.mode = MODE_RANGE;
        else if (pick < 85) r.mode = MODE_CHANCE;
        else if (pick < 95) r.mode = MODE_HASH;
        else                r.mode = 3'($urandom_range(5, 7));
        if (r.mode == MODE_CHANCE && $urandom_range(0, 1))
            r.chance_num = r.chance_den >> $urandom_range(0, 4);
        return r;
    endfunction

    task automatic send_request(input t_request r);
        while (!steady && $urandom_range(0, 99) < 37) begin
            i_valid = 1'b0;
            @(negedge i_clk);
        end
        i_valid       = 1'b1;
        i_mode        = r.mode;
        i_limit_low   = r.limit_low;
        i_limit_high  = r.limit_high;
        i_chance_num  = r.chance_num;
        i_chance_den  = r.chance_den;
        i_hash_offset = r.hash_offset;
        do @(posedge i_clk); while (o_stall);
        draws.note_request(r);
        @(negedge i_clk);
    endtask

    task automatic end_burst();
        i_valid = 1'b0;
        while (draws.pending() != 0)
            @(negedge i_clk);
    endtask

    task automatic write_seed(input logic [DATA_W-1:0] value);
        i_cfg_valid = 1'b1;
        i_seed      = value;
        do @(posedge i_clk); while (!o_cfg_ready);
        draws.load_seed(value);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    task automatic run_random(input int count, input int steady_from, input int steady_to);
        for (int n = 0; n < count; n++) begin
            steady = (n >= steady_from && n < steady_to);
            send_request(random_request());
        end
        steady = 1'b0;
        end_burst();
    endtask

    task automatic run_directed();
        send_request(make_request(MODE_RAW, '0, '0, '0, '0, '0));
        send_request(make_request(MODE_RAW, '1, '1, '1, '1, '1));
        send_request(make_request(MODE_MOD, '0, 32'hFFFF_FFFF, '0, '0, '0));
        send_request(make_request(MODE_MOD, '1, 32'd0, '1, '1, '1));
        send_request(make_request(MODE_MOD, '0, 32'hFFFF_FFFE, '0, '0, '0));
        send_request(make_request(MODE_MOD, '0, 32'd9, '0, '0, '0));
        send_request(make_request(MODE_RANGE, 32'd100, 32'd10, '0, '0, '0));
        send_request(make_request(MODE_RANGE, 32'd0, 32'hFFFF_FFFF, '0, '0, '0));
        send_request(make_request(MODE_RANGE, 32'hFFFF_FFFF, 32'd0, '0, '0, '0));
        send_request(make_request(MODE_RANGE, 32'd77, 32'd77, '0, '0, '0));
        send_request(make_request(MODE_RANGE, 32'hFFFF_FFFF, 32'hFFFF_FFFF, '1, '1, '1));
        send_request(make_request(MODE_RANGE, 32'h8000_0000, 32'hFFFF_FFF0, '0, '0, '0));
        send_request(make_request(MODE_CHANCE, '0, '0, 32'd0, 32'd0, '0));
        send_request(make_request(MODE_CHANCE, '0, '0, 32'd1, 32'd0, '0));
        send_request(make_request(MODE_CHANCE, '0, '0, 32'd5, 32'd3, '0));
        send_request(make_request(MODE_CHANCE, '0, '0, 32'd0, 32'hFFFF_FFFF, '0));
        send_request(make_request(MODE_CHANCE, '0, '0, '1, '1, '0));
        send_request(make_request(MODE_CHANCE, '0, '0, 32'd1, 32'd2, '0));
        send_request(make_request(MODE_CHANCE, '1, '1, 32'hFFFF_FFFF, 32'd1, '1));
        send_request(make_request(MODE_HASH, '0, '0, '0, '0, 32'd0));
        send_request(make_request(MODE_HASH, '0, '0, '0, '0, 32'hFFFF_FFFF));
        send_request(make_request(MODE_HASH, '1, '1, '1, '1, 32'h1234_5678));
        send_request(make_request(3'd5, '0, 32'd3, '0, '0, '0));
        send_request(make_request(3'd6, '1, '1, '1, '1, '1));
        send_request(make_request(3'd7, '0, 32'd3, 32'd1, '0, '0));
        end_burst();
    endtask

    task automatic run_zero_state();
        send_request(make_request(MODE_RAW, '0, '0, '0, '0, '0));
        send_request(make_request(MODE_MOD, '0, 32'd6, '0, '0, '0));
        send_request(make_request(MODE_RANGE, 32'd40, 32'd20, '0, '0, '0));
        send_request(make_request(MODE_CHANCE, '0, '0, 32'd0, 32'd9, '0));
        send_request(make_request(MODE_CHANCE, '0, '0, 32'd1, 32'hFFFF_FFFF, '0));
        send_request(make_request(MODE_HASH, '0, '0, '0, '0, 32'hDEAD_BEEF));
        send_request(make_request(MODE_RAW, '1, '1, '1, '1, '1));
        end_burst();
    endtask

    initial begin
        int unsigned hold_cycles;
        bit          hold_done;
        hold_cycles = 0;
        hold_done   = 1'b0;
        i_stall     = 1'b0;
        forever begin
            @(posedge i_clk);
            if (o_valid && !i_stall) begin
                draws.check_draw(o_value, o_hit);
                results_seen++;
            end
            @(negedge i_clk);
            if (!hold_done && results_seen >= HOLD_AT) begin
                hold_done   = 1'b1;
                hold_cycles = HOLD_OFF;
            end
            if (hold_cycles > 0) begin
                i_stall = 1'b1;
                hold_cycles--;
            end else if (steady) begin
                i_stall = 1'b0;
            end else begin
                i_stall = ($urandom_range(0, 99) < 37);
            end
        end
    end

    initial begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < WATCHDOG_LIMIT) begin
            @(posedge i_clk);
            if ((i_valid && !o_stall) || (o_valid && !i_stall) ||
                (i_cfg_valid && o_cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no transaction for %0d cycles", $time, WATCHDOG_LIMIT);
        $display("Some tests failed");
        $finish;
    end

    initial begin
        i_rst_n       = 1'b0;
        i_valid       = 1'b0;
        i_mode        = MODE_RAW;
        i_limit_low   = '0;
        i_limit_high  = '0;
        i_chance_num  = '0;
        i_chance_den  = '0;
        i_hash_offset = '0;
        i_cfg_valid   = 1'b0;
        i_seed        = '0;
        repeat (11) @(negedge i_clk);
        i_rst_n = 1'b1;
        @(negedge i_clk);

        run_directed();
        write_seed(32'd0);
        run_zero_state();
        write_seed(32'hFFFF_FFFF);
        run_random(350, 0, 0);
        write_seed($urandom);
        run_random(400, 100, 250);
        write_seed(32'h8000_0000);
        run_random(350, 0, 0);

        repeat (DRAIN_CYCLES) @(negedge i_clk);
        if (draws.pending() != 0) begin
            $display("%0t: %0d expected results never arrived", $time, draws.pending());
            draws.errors++;
        end
        if (draws.errors == 0)
            $display("All tests passed");
        else
            $display("Some tests failed");
        $finish;
    end

endmodule
